// ===== sv/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants for the cubic Bezier curvature block.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int MUL_CHUNK   = 24;
  localparam int MUL_LAT     = 4;
  localparam int Q_BITS      = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 2;
  localparam int POINT_W     = 63;

  localparam logic [CFG_IDX_W-1:0] REG_POINT0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT3 = 2'd3;

  localparam logic [Q_BITS-1:0] CURV_SAT = '1;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== sv/cbc_mul.sv =====
// ----------------------------------------------------------------------------
// cbc_mul
// Pipelined signed multiplier built from narrow partial products.
// ----------------------------------------------------------------------------
module cbc_mul import cbc_pkg::*; #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [AW-1:0]      a_i,
  input  logic signed [BW-1:0]      b_i,
  output logic signed [AW+BW-1:0]   p_o
);

  localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int PW = AW + BW;

  logic [AW-1:0]              mag_a;
  logic [BW-1:0]              mag_b;
  logic [NA*MUL_CHUNK-1:0]    ma_q;
  logic [NB*MUL_CHUNK-1:0]    mb_q;
  logic                       neg1_q, neg2_q, neg3_q;
  logic [2*MUL_CHUNK-1:0]     pp_q [NA][NB];
  logic [PW-1:0]              sum_d, sum_q;
  logic signed [PW-1:0]       p_q;

  assign mag_a = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign mag_b = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (PW'(pp_q[i][j]) << ((i + j) * MUL_CHUNK));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= (NA*MUL_CHUNK)'(mag_a);
      mb_q   <= (NB*MUL_CHUNK)'(mag_b);
      neg1_q <= a_i[AW-1] ^ b_i[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= ma_q[i*MUL_CHUNK +: MUL_CHUNK] * mb_q[j*MUL_CHUNK +: MUL_CHUNK];
        end
      end
      neg2_q <= neg1_q;
      sum_q  <= sum_d;
      neg3_q <= neg2_q;
      p_q    <= neg3_q ? $signed(-sum_q) : $signed(sum_q);
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/cbc_queue.sv =====
// ----------------------------------------------------------------------------
// cbc_queue
// Short queue between the accepting front and the computing back end.
// ----------------------------------------------------------------------------
module cbc_queue import cbc_pkg::*; #(
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  input  logic          pop_i,
  output logic [DW-1:0] pop_data_o,
  output qstat_t        stat_o
);

  logic [DW-1:0]     mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

// ===== sv/cbc_front.sv =====
// ----------------------------------------------------------------------------
// cbc_front
// Input side: accept the curve parameter and clamp it to one.
// ----------------------------------------------------------------------------
module cbc_front import cbc_pkg::*; #(
  parameter int TF = 15
) (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [15:0]   param_t_i,
  input  qstat_t        qstat_i,
  output logic          push_o,
  output logic [TF:0]   push_data_o
);

  localparam int TXW = (TF + 1 > 16) ? TF + 1 : 16;
  localparam logic [TXW-1:0] T_ONE = TXW'(1) << TF;

  logic [TXW-1:0] t_ext;

  assign t_ext       = TXW'(param_t_i);
  assign in_stall_o  = qstat_i.full;
  assign push_o      = in_valid_i && !qstat_i.full;
  assign push_data_o = (t_ext > T_ONE) ? (TF+1)'(T_ONE) : t_ext[TF:0];

endmodule

// ===== sv/cbc_back.sv =====
// ----------------------------------------------------------------------------
// cbc_back
// Curvature datapath: derivatives, cross product, norms and exact root search.
// ----------------------------------------------------------------------------
module cbc_back import cbc_pkg::*; #(
  parameter int CW = 21,
  parameter int TF = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [POINT_W-1:0]  point0_i,
  input  logic [POINT_W-1:0]  point1_i,
  input  logic [POINT_W-1:0]  point2_i,
  input  logic [POINT_W-1:0]  point3_i,
  input  qstat_t              qstat_i,
  input  logic [TF:0]         q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [Q_BITS-1:0]   curvature_o,
  output logic                degenerate_o,
  output logic                saturated_o
);

  localparam int TW   = TF + 1;
  localparam int DW   = CW + 1;
  localparam int EW   = CW + 2;
  localparam int WW   = 2*TF + 1;
  localparam int AW   = 2*TF + CW + 2;
  localparam int BW   = TF + CW + 3;
  localparam int CXW  = AW + BW + 1;
  localparam int NAW  = 2*AW + 1;
  localparam int NCW  = 2*CXW + 1;
  localparam int N2W  = 2*NAW;
  localparam int N3W  = N2W + NAW;
  localparam int SH   = 6*TF + 54;
  localparam int RW1  = NCW + SH;
  localparam int RW2  = N3W + 4 + 2*Q_BITS + 2;
  localparam int RW   = ((RW1 > RW2) ? RW1 : RW2) + 1;
  localparam int NSTG = 3 + MUL_LAT + 1 + MUL_LAT + 1 + MUL_LAT + 2 + Q_BITS + 1;
  localparam logic [TW-1:0] T_ONE = TW'(1) << TF;

  logic                  en;
  logic [NSTG-1:0]       vld_q;
  logic [POINT_W-1:0]    pts [4];
  logic signed [CW-1:0]  pc [4][3];
  logic signed [DW-1:0]  da [3], db [3], dc [3];
  logic signed [EW-1:0]  dba [3], dcb [3];
  logic [TW-1:0]         u, v;

  logic [WW-1:0]         vv_q, uv2_q, uu_q;
  logic signed [BW-1:0]  b_d [3], b1_q [3], b2_q [3], b3_q [3];
  logic signed [AW-1:0]  pr_q [3][3];
  logic signed [AW-1:0]  a_q [3];

  logic signed [AW+BW-1:0] xp [3], xn [3];
  logic signed [2*AW-1:0]  asq [3];
  logic signed [CXW-1:0]   c_q [3];
  logic signed [NAW-1:0]   na_q;
  logic signed [NAW-1:0]   na_dly_q [MUL_LAT+1];
  logic signed [2*CXW-1:0] csq [3];
  logic signed [N2W-1:0]   na2, n2_q;
  logic signed [NCW-1:0]   nc_q;
  logic signed [NCW-1:0]   nc_dly_q [MUL_LAT];
  logic signed [N3W-1:0]   na3;
  logic [RW-1:0]           w18_q, r18_q;

  logic [RW-1:0]           sr_q [Q_BITS+1];
  logic [RW-1:0]           sp_q [Q_BITS+1];
  logic [RW-1:0]           sw_q [Q_BITS+1];
  logic [Q_BITS-1:0]       sq_q [Q_BITS+1];
  logic                    sat_q [Q_BITS+1];
  logic                    dgn_q [Q_BITS+1];
  logic [RW-1:0]           cand [Q_BITS];
  logic                    take [Q_BITS];

  logic [Q_BITS-1:0]       curv_q;
  logic                    dgn_out_q, sat_out_q;

  assign en    = !vld_q[NSTG-1] || !out_stall_i;
  assign pop_o = en && !qstat_i.empty;
  assign pts   = '{point0_i, point1_i, point2_i, point3_i};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int ax = 0; ax < 3; ax++) begin
        pc[k][ax] = $signed(pts[k][ax*CW +: CW]);
      end
    end
    for (int ax = 0; ax < 3; ax++) begin
      da[ax]  = DW'(pc[1][ax]) - DW'(pc[0][ax]);
      db[ax]  = DW'(pc[2][ax]) - DW'(pc[1][ax]);
      dc[ax]  = DW'(pc[3][ax]) - DW'(pc[2][ax]);
      dba[ax] = EW'(db[ax]) - EW'(da[ax]);
      dcb[ax] = EW'(dc[ax]) - EW'(db[ax]);
    end
  end

  assign u = q_data_i;
  assign v = T_ONE - u;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      b_d[ax] = BW'($signed({1'b0, v})) * BW'(dba[ax])
              + BW'($signed({1'b0, u})) * BW'(dcb[ax]);
    end
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_lane
    localparam int I = (ax + 1) % 3;
    localparam int J = (ax + 2) % 3;
    cbc_mul #(.AW(AW), .BW(BW)) u_xp (
      .clk_i, .en_i(en), .a_i(a_q[I]), .b_i(b3_q[J]), .p_o(xp[ax])
    );
    cbc_mul #(.AW(AW), .BW(BW)) u_xn (
      .clk_i, .en_i(en), .a_i(a_q[J]), .b_i(b3_q[I]), .p_o(xn[ax])
    );
    cbc_mul #(.AW(AW), .BW(AW)) u_asq (
      .clk_i, .en_i(en), .a_i(a_q[ax]), .b_i(a_q[ax]), .p_o(asq[ax])
    );
    cbc_mul #(.AW(CXW), .BW(CXW)) u_csq (
      .clk_i, .en_i(en), .a_i(c_q[ax]), .b_i(c_q[ax]), .p_o(csq[ax])
    );
  end

  cbc_mul #(.AW(NAW), .BW(NAW)) u_na2 (
    .clk_i, .en_i(en), .a_i(na_q), .b_i(na_q), .p_o(na2)
  );

  cbc_mul #(.AW(N2W), .BW(NAW)) u_na3 (
    .clk_i, .en_i(en), .a_i(n2_q), .b_i(na_dly_q[MUL_LAT]), .p_o(na3)
  );

  always_comb begin
    for (int k = 0; k < Q_BITS; k++) begin
      cand[k] = (sp_q[k] << (Q_BITS - k)) + (sw_q[k] << (2 * (Q_BITS - 1 - k)));
      take[k] = (sr_q[k] >= cand[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vv_q  <= WW'(v) * WW'(v);
      uv2_q <= (WW'(u) * WW'(v)) << 1;
      uu_q  <= WW'(u) * WW'(u);
      for (int ax = 0; ax < 3; ax++) begin
        b1_q[ax]     <= b_d[ax];
        pr_q[ax][0]  <= AW'($signed({1'b0, vv_q})) * AW'(da[ax]);
        pr_q[ax][1]  <= AW'($signed({1'b0, uv2_q})) * AW'(db[ax]);
        pr_q[ax][2]  <= AW'($signed({1'b0, uu_q})) * AW'(dc[ax]);
        b2_q[ax]     <= b1_q[ax];
        a_q[ax]      <= pr_q[ax][0] + pr_q[ax][1] + pr_q[ax][2];
        b3_q[ax]     <= b2_q[ax];
        c_q[ax]      <= CXW'(xp[ax]) - CXW'(xn[ax]);
      end
      na_q <= NAW'(asq[0]) + NAW'(asq[1]) + NAW'(asq[2]);
      na_dly_q[0] <= na_q;
      for (int k = 1; k <= MUL_LAT; k++) na_dly_q[k] <= na_dly_q[k-1];
      nc_q <= NCW'(csq[0]) + NCW'(csq[1]) + NCW'(csq[2]);
      n2_q <= na2;
      nc_dly_q[0] <= nc_q;
      for (int k = 1; k < MUL_LAT; k++) nc_dly_q[k] <= nc_dly_q[k-1];
      w18_q <= (RW'(na3) << 3) + RW'(na3);
      r18_q <= RW'(nc_dly_q[MUL_LAT-1]) << SH;

      sr_q[0]  <= r18_q;
      sp_q[0]  <= '0;
      sw_q[0]  <= w18_q;
      sq_q[0]  <= '0;
      sat_q[0] <= (r18_q >= (w18_q << (2 * Q_BITS)));
      dgn_q[0] <= (w18_q == '0);
      for (int k = 0; k < Q_BITS; k++) begin
        sr_q[k+1]  <= take[k] ? sr_q[k] - cand[k] : sr_q[k];
        sp_q[k+1]  <= take[k] ? sp_q[k] + (sw_q[k] << (Q_BITS - 1 - k)) : sp_q[k];
        sq_q[k+1]  <= sq_q[k] | (Q_BITS'(take[k]) << (Q_BITS - 1 - k));
        sw_q[k+1]  <= sw_q[k];
        sat_q[k+1] <= sat_q[k];
        dgn_q[k+1] <= dgn_q[k];
      end

      priority if (dgn_q[Q_BITS]) begin
        curv_q    <= '0;
        dgn_out_q <= 1'b1;
        sat_out_q <= 1'b0;
      end else if (sat_q[Q_BITS]) begin
        curv_q    <= CURV_SAT;
        dgn_out_q <= 1'b0;
        sat_out_q <= 1'b1;
      end else begin
        curv_q    <= sq_q[Q_BITS];
        dgn_out_q <= 1'b0;
        sat_out_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = vld_q[NSTG-1];
  assign curvature_o  = curv_q;
  assign degenerate_o = dgn_out_q;
  assign saturated_o  = sat_out_q;

endmodule

// ===== sv/cubic_bezier_curvature_top.sv =====
// Path: each input transaction is held in the queue, then goes through the
//   52-stage datapath (derivatives, cross product, norms, one bit per root
//   stage).
// Throughput: one transaction per cycle while out_stall_i is low.
// Reset: asynchronous, active low; clears control state and the four control
//   points to zero. No clearing pass.
// ----------------------------------------------------------------------------
// cubic_bezier_curvature_top
// Curvature of a 3-D cubic Bezier curve at a parameter t, unsigned Q6.26.
// ----------------------------------------------------------------------------
module cubic_bezier_curvature_top import cbc_pkg::*; #(
  parameter int COORD_WIDTH = 21,
  parameter int T_FRAC_BITS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          param_t_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [Q_BITS-1:0]    curvature_o,
  output logic                 degenerate_o,
  output logic                 saturated_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [POINT_W-1:0]   cfg_data_i
);

  logic [POINT_W-1:0] point0_q, point1_q, point2_q, point3_q;
  qstat_t             qstat;
  logic               push, pop;
  logic [T_FRAC_BITS:0] push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point0_q <= '0;
      point1_q <= '0;
      point2_q <= '0;
      point3_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_POINT0: point0_q <= cfg_data_i;
        REG_POINT1: point1_q <= cfg_data_i;
        REG_POINT2: point2_q <= cfg_data_i;
        REG_POINT3: point3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cbc_front #(.TF(T_FRAC_BITS)) u_front (
    .in_valid_i, .in_stall_o, .param_t_i,
    .qstat_i(qstat), .push_o(push), .push_data_o(push_data)
  );

  cbc_queue #(.DW(T_FRAC_BITS + 1)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data),
    .pop_i(pop), .pop_data_o(pop_data), .stat_o(qstat)
  );

  cbc_back #(.CW(COORD_WIDTH), .TF(T_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .point0_i(point0_q), .point1_i(point1_q), .point2_i(point2_q), .point3_i(point3_q),
    .qstat_i(qstat), .q_data_i(pop_data), .pop_o(pop),
    .out_valid_o, .out_stall_i, .curvature_o, .degenerate_o, .saturated_o
  );

endmodule
